/* sv/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants for the PNG chunk deframer: the result record,
// the error codes, the file signature, the chunk tags and the IHDR fields.
// ----------------------------------------------------------------------------
package pcd_pkg;

    // Error codes reported on error_code.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_DEPTH     = 3'd2,
        ERR_COLOUR    = 3'd3,
        ERR_INTERLACE = 3'd4,
        ERR_TRUNCATED = 3'd5
    } err_t;

    // One result item, as it travels from the parser to the output buffer.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  sample_depth;
        logic        header_seen;
        logic        stream_done;
        logic [2:0]  error_code;
    } result_t;

    // The eight bytes that open every PNG file.
    localparam logic [7:0] SIGNATURE [8] = '{
        8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
    };

    // Chunk type tags, as four big-endian ASCII bytes.
    localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
    localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
    localparam logic [31:0] TAG_IEND = 32'h4945_4e44;

    // IHDR field values that are accepted.
    localparam logic [7:0] DEPTH_8     = 8'd8;
    localparam logic [7:0] DEPTH_16    = 8'd16;
    localparam logic [7:0] COLOUR_RGBA = 8'd6;

    // IHDR data byte positions.
    localparam logic [31:0] IHDR_DEPTH_IDX     = 32'd8;
    localparam logic [31:0] IHDR_COLOUR_IDX    = 32'd9;
    localparam logic [31:0] IHDR_INTERLACE_IDX = 32'd12;

endpackage

/* sv/pcd_parser.sv */
// ----------------------------------------------------------------------------
// pcd_parser
// Holds the parse state and updates it by one byte per accepted
// transaction, forming the result that belongs to that byte.
// ----------------------------------------------------------------------------
module pcd_parser
    import pcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_HALT = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_IHDR  = 2'd1,
        KIND_IDAT  = 2'd2,
        KIND_IEND  = 2'd3
    } kind_t;

    phase_t      phase_reg,  phase_next;
    logic [31:0] count_reg,  count_next;
    logic [31:0] length_reg, length_next;
    kind_t       kind_reg,   kind_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] width_reg,  width_next;
    logic [31:0] height_reg, height_next;
    logic [7:0]  depth_reg,  depth_next;
    logic        header_reg, header_next;
    logic        done_reg,   done_next;
    err_t        error_reg,  error_next;

    logic [31:0] count_inc;
    logic [31:0] tag_shift;
    logic [7:0]  pay_byte;
    logic        pay_valid;
    logic        halted;

    assign count_inc = count_reg + 32'd1;
    assign tag_shift = {tag_reg[23:0], data_byte};

    // Next state for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        tag_next    = tag_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        header_next = header_reg;
        done_next   = done_reg;
        error_next  = error_reg;
        pay_byte    = 8'd0;
        pay_valid   = 1'b0;
        halted      = 1'b0;

        case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != SIGNATURE[count_reg[2:0]]) begin
                    error_next = ERR_SIGNATURE;
                    phase_next = PH_HALT;
                end else if (count_reg[2:0] == 3'd7) begin
                    count_next  = '0;
                    length_next = '0;
                    phase_next  = PH_LEN;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_LEN:
            begin
                length_next = {length_reg[23:0], data_byte};
                if (count_reg[1:0] == 2'd3) begin
                    count_next = '0;
                    tag_next   = '0;
                    phase_next = PH_TYPE;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_TYPE:
            begin
                tag_next = tag_shift;
                if (count_reg[1:0] == 2'd3) begin
                    count_next = '0;
                    if (tag_shift == TAG_IEND) begin
                        kind_next  = KIND_IEND;
                        done_next  = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        if (tag_shift == TAG_IHDR) begin
                            kind_next = KIND_IHDR;
                        end else if (tag_shift == TAG_IDAT) begin
                            kind_next = KIND_IDAT;
                        end else begin
                            kind_next = KIND_OTHER;
                        end
                        phase_next = (length_reg == 32'd0) ? PH_CRC : PH_DATA;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_DATA:
            begin
                if (kind_reg == KIND_IDAT) begin
                    pay_byte  = data_byte;
                    pay_valid = 1'b1;
                end else if (kind_reg == KIND_IHDR) begin
                    // IHDR fields are taken and checked as their bytes arrive.
                    if (count_reg < 32'd4) begin
                        width_next = {width_reg[23:0], data_byte};
                    end else if (count_reg < IHDR_DEPTH_IDX) begin
                        height_next = {height_reg[23:0], data_byte};
                    end else if (count_reg == IHDR_DEPTH_IDX) begin
                        depth_next = data_byte;
                        if (data_byte != DEPTH_8 && data_byte != DEPTH_16) begin
                            error_next = ERR_DEPTH;
                            halted     = 1'b1;
                        end
                    end else if (count_reg == IHDR_COLOUR_IDX) begin
                        if (data_byte != COLOUR_RGBA) begin
                            error_next = ERR_COLOUR;
                            halted     = 1'b1;
                        end
                    end else if (count_reg == IHDR_INTERLACE_IDX) begin
                        if (data_byte != 8'd0) begin
                            error_next = ERR_INTERLACE;
                            halted     = 1'b1;
                        end else begin
                            header_next = 1'b1;
                        end
                    end
                end
                if (halted) begin
                    phase_next = PH_HALT;
                end else if (count_inc == length_reg) begin
                    count_next = '0;
                    phase_next = PH_CRC;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                if (count_reg[1:0] == 2'd3) begin
                    count_next  = '0;
                    length_next = '0;
                    phase_next  = PH_LEN;
                end else begin
                    count_next = count_inc;
                end
            end
            default:
            begin
            end
        endcase

        // Input that ends before IEND is truncated.
        if (last_byte && phase_next != PH_DONE && phase_next != PH_HALT) begin
            error_next = ERR_TRUNCATED;
            phase_next = PH_HALT;
        end
    end

    // The result shows the state after this byte.
    always_comb
    begin
        result.payload_byte  = pay_byte;
        result.payload_valid = pay_valid;
        result.image_width   = width_next;
        result.image_height  = height_next;
        result.sample_depth  = depth_next;
        result.header_seen   = header_next;
        result.stream_done   = done_next;
        result.error_code    = error_next;
    end

    // Parse state registers, advanced once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_SIG;
            count_reg  <= '0;
            length_reg <= '0;
            kind_reg   <= KIND_OTHER;
            tag_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            header_reg <= 1'b0;
            done_reg   <= 1'b0;
            error_reg  <= ERR_NONE;
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            kind_reg   <= kind_next;
            tag_reg    <= tag_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            header_reg <= header_next;
            done_reg   <= done_next;
            error_reg  <= error_next;
        end
    end

endmodule

/* sv/pcd_out_buf.sv */
// ----------------------------------------------------------------------------
// pcd_out_buf
// Two-entry output buffer: a result register and a skid register, so that
// input is still taken while a result waits for the receiver.
// ----------------------------------------------------------------------------
module pcd_out_buf
    import pcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Control: occupancy of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Data: the skid entry refills the result register when it drains.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

/* sv/png_chunk_deframer.sv */
// ----------------------------------------------------------------------------
// png_chunk_deframer
// Walks a PNG byte stream: checks the signature, decodes chunk headers,
// takes IHDR fields, passes IDAT data out and stops at IEND.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready, data_byte, last_byte) carries the
// file one byte per transaction; last_byte marks the final byte. Every input
// transaction yields exactly one output transaction (out_valid/out_ready)
// holding the IDAT byte, if any, and the current header, done and error
// status. The CRC of each chunk is skipped, not checked.
// A byte taken is registered into the result register, or into the skid
// register while the receiver stalls. Throughput is one byte per cycle while
// in_ready is high, set by the single parse state update before the result register.
// A two-entry output buffer keeps taking bytes while the receiver stalls;
// in_ready falls only once both entries hold results.
// Reset returns the parser to the signature check and clears all fields,
// flags and the error code. Errors are sticky until reset.
// ----------------------------------------------------------------------------
module png_chunk_deframer
    import pcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [7:0]  sample_depth,
    output logic        header_seen,
    output logic        stream_done,
    output logic [2:0]  error_code
);

    logic    fire;
    result_t step_result;
    result_t out_data;

    assign fire = in_valid & in_ready;

    // Byte parser.
    pcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .result    (step_result)
    );

    // Result register with skid entry.
    pcd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Result fields onto their ports.
    assign payload_byte  = out_data.payload_byte;
    assign payload_valid = out_data.payload_valid;
    assign image_width   = out_data.image_width;
    assign image_height  = out_data.image_height;
    assign sample_depth  = out_data.sample_depth;
    assign header_seen   = out_data.header_seen;
    assign stream_done   = out_data.stream_done;
    assign error_code    = out_data.error_code;

endmodule

/* test/png_chunk_deframer_test.sv */
// ----------------------------------------------------------------------------
// png_chunk_deframer_test
// Feeds the deframer a single PNG byte stream. The stream opens with a fixed
// table (signature and an IHDR with extreme fields) and goes on with random chunks of
// every kind but IEND. It then ends by IEND, by truncation or by a failing IHDR check,
// and ignored bytes follow. Each output transaction is checked field by field against
// the table where it gives a result, else a bit-accurate model of the parser kept here.
// ----------------------------------------------------------------------------
module png_chunk_deframer_test
    import pcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET  = 1850;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Parse phases and chunk kinds of the model.
    typedef enum logic [2:0] {
        ST_SIGNATURE, ST_LENGTH, ST_TYPE, ST_DATA, ST_CRC, ST_DONE, ST_HALTED
    } parse_phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER, KIND_IHDR, KIND_IDAT, KIND_IEND
    } chunk_kind_t;

    // One byte of the file, with a typed expectation where one is given.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    want;
    } file_byte_t;

    localparam result_t STATUS_CLEAR  = '0;
    localparam result_t HEADER_LOADED = '{8'h00, 1'b0, 32'hffff_ffff, 32'h0000_0000,
                                          DEPTH_16, 1'b1, 1'b0, ERR_NONE};

    // Opening table: the signature, then an IHDR with the widest width,
    // zero height and depth 16.
    localparam file_byte_t OPENING [29] = '{
        '{8'h89, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h50, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h4e, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h47, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h0d, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h0a, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h1a, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h0a, 1'b0, 1'b1, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h0d, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h49, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h48, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h44, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h52, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'hff, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'hff, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'hff, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'hff, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h10, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h06, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b0, STATUS_CLEAR},
        '{8'h00, 1'b0, 1'b1, HEADER_LOADED}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic        header_seen;
    logic        stream_done;
    logic [2:0]  error_code;

    png_chunk_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .image_width   (image_width),
        .image_height  (image_height),
        .sample_depth  (sample_depth),
        .header_seen   (header_seen),
        .stream_done   (stream_done),
        .error_code    (error_code)
    );

    // Parser model state, at its reset values.
    parse_phase_t m_phase  = ST_SIGNATURE;
    logic [31:0]  m_count  = '0;
    logic [31:0]  m_length = '0;
    chunk_kind_t  m_kind   = KIND_OTHER;
    logic [31:0]  m_tag    = '0;
    logic [31:0]  m_width  = '0;
    logic [31:0]  m_height = '0;
    logic [7:0]   m_depth  = '0;
    logic         m_header = 1'b0;
    logic         m_done   = 1'b0;
    err_t         m_error  = ERR_NONE;

    file_byte_t   file_bytes[$];
    result_t      due_outputs[$];
    int unsigned  accepted_count = 0;
    int unsigned  result_count   = 0;
    int unsigned  payload_count  = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  send_calm      = 0;
    int unsigned  recv_calm      = 0;
    string        ending_name    = "";

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The first failing check, or truncation, halts the parser for good.
    function automatic void halt_parse(input err_t code);
        m_error = code;
        m_phase = ST_HALTED;
    endfunction

    // Advances the parser model by one file byte and returns its outputs.
    function automatic result_t deframe_byte(input logic [7:0] b, input logic last);
        result_t r;
        r = '0;
        case (m_phase)
            ST_SIGNATURE:
            begin
                if (b != SIGNATURE[m_count[2:0]])
                begin
                    halt_parse(ERR_SIGNATURE);
                end
                else
                begin
                    m_count = m_count + 1;
                    if (m_count >= 8)
                    begin
                        m_count  = '0;
                        m_length = '0;
                        m_phase  = ST_LENGTH;
                    end
                end
            end
            ST_LENGTH:
            begin
                m_length = {m_length[23:0], b};
                m_count  = m_count + 1;
                if (m_count >= 4)
                begin
                    m_count = '0;
                    m_tag   = '0;
                    m_phase = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                m_tag   = {m_tag[23:0], b};
                m_count = m_count + 1;
                if (m_count >= 4)
                begin
                    m_count = '0;
                    if (m_tag == TAG_IHDR)
                        m_kind = KIND_IHDR;
                    else if (m_tag == TAG_IDAT)
                        m_kind = KIND_IDAT;
                    else if (m_tag == TAG_IEND)
                        m_kind = KIND_IEND;
                    else
                        m_kind = KIND_OTHER;
                    if (m_kind == KIND_IEND)
                    begin
                        m_done  = 1'b1;
                        m_phase = ST_DONE;
                    end
                    else
                    begin
                        m_phase = (m_length == 0) ? ST_CRC : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (m_kind == KIND_IDAT)
                begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                end
                else if (m_kind == KIND_IHDR)
                begin
                    // IHDR checks run as their bytes arrive.
                    if (m_count < 4)
                    begin
                        m_width = {m_width[23:0], b};
                    end
                    else if (m_count < 8)
                    begin
                        m_height = {m_height[23:0], b};
                    end
                    else if (m_count == IHDR_DEPTH_IDX)
                    begin
                        m_depth = b;
                        if (b != DEPTH_8 && b != DEPTH_16)
                            halt_parse(ERR_DEPTH);
                    end
                    else if (m_count == IHDR_COLOUR_IDX)
                    begin
                        if (b != COLOUR_RGBA)
                            halt_parse(ERR_COLOUR);
                    end
                    else if (m_count == IHDR_INTERLACE_IDX)
                    begin
                        if (b != 8'h00)
                            halt_parse(ERR_INTERLACE);
                        else
                            m_header = 1'b1;
                    end
                end
                if (m_phase == ST_DATA)
                begin
                    m_count = m_count + 1;
                    if (m_count == m_length)
                    begin
                        m_count = '0;
                        m_phase = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                m_count = m_count + 1;
                if (m_count >= 4)
                begin
                    m_count  = '0;
                    m_length = '0;
                    m_phase  = ST_LENGTH;
                end
            end
            default:
            begin
            end
        endcase

        // A check error on this byte wins over truncation.
        if (last && m_phase != ST_DONE && m_phase != ST_HALTED)
            halt_parse(ERR_TRUNCATED);

        r.image_width  = m_width;
        r.image_height = m_height;
        r.sample_depth = m_depth;
        r.header_seen  = m_header;
        r.stream_done  = m_done;
        r.error_code   = m_error;
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last);
        file_byte_t fb;
        fb       = '0;
        fb.data  = b;
        fb.last  = last;
        file_bytes.push_back(fb);
    endfunction

    // Big-endian, as PNG lengths and tags are stored.
    function automatic void push_word(input logic [31:0] w);
        push_byte(w[31:24], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[15:8], 1'b0);
        push_byte(w[7:0], 1'b0);
    endfunction

    // One IHDR data byte: legal check bytes unless the named check is to fail.
    function automatic logic [7:0] ihdr_field(input int unsigned idx, input err_t fault);
        logic [7:0] v;
        v = 8'($urandom);
        if (idx == IHDR_DEPTH_IDX)
        begin
            if (fault == ERR_DEPTH)
            begin
                while (v == DEPTH_8 || v == DEPTH_16)
                    v = 8'($urandom);
            end
            else
            begin
                v = ($urandom_range(0, 1) != 0) ? DEPTH_16 : DEPTH_8;
            end
        end
        else if (idx == IHDR_COLOUR_IDX)
        begin
            if (fault == ERR_COLOUR)
            begin
                while (v == COLOUR_RGBA)
                    v = 8'($urandom);
            end
            else
            begin
                v = COLOUR_RGBA;
            end
        end
        else if (idx == IHDR_INTERLACE_IDX)
        begin
            v = (fault == ERR_INTERLACE) ? 8'($urandom_range(1, 255)) : 8'h00;
        end
        return v;
    endfunction

    // Random chunks after the opening table, then one way of ending, then
    // bytes that the halted or finished parser must ignore.
    task automatic build_random_file();
        int unsigned sel;
        int unsigned len;
        int unsigned k;
        int unsigned start;
        int unsigned cut;
        int unsigned fail_at;
        logic [31:0] tag;
        err_t        fault;

        // CRC of the opening IHDR.
        push_word($urandom);
        while (file_bytes.size() < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                tag = TAG_IDAT;
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            end
            else if (sel < 65)
            begin
                tag = $urandom;
                len = $urandom_range(0, 20);
            end
            else if (sel < 77)
            begin
                // A tag one byte away from IEND or IDAT.
                tag = ($urandom_range(0, 1) != 0) ? TAG_IEND : TAG_IDAT;
                tag = tag ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
                len = $urandom_range(0, 12);
            end
            else
            begin
                // Repeated IHDR, sometimes short or padded.
                tag = TAG_IHDR;
                k   = $urandom_range(0, 9);
                len = (k < 7) ? 13 : (k < 8) ? $urandom_range(0, 12) : $urandom_range(14, 24);
            end
            push_word(len);
            push_word(tag);
            for (k = 0; k < len; k++)
                push_byte((tag == TAG_IHDR) ? ihdr_field(k, ERR_NONE) : 8'($urandom), 1'b0);
            push_word($urandom);
        end

        sel = $urandom_range(0, 3);
        if (sel < 2)
        begin
            // IEND; last_byte on its final tag byte must not count as truncation.
            ending_name = "IEND";
            push_word($urandom);
            push_byte(TAG_IEND[31:24], 1'b0);
            push_byte(TAG_IEND[23:16], 1'b0);
            push_byte(TAG_IEND[15:8], 1'b0);
            push_byte(TAG_IEND[7:0], 1'($urandom_range(0, 1)));
        end
        else if (sel == 2)
        begin
            // A chunk cut short at a random byte of its header or data.
            ending_name = "truncation";
            start = file_bytes.size();
            push_word(($urandom_range(0, 3) == 0) ? 32'hffff_ffff : 32'($urandom));
            push_word(($urandom_range(0, 1) != 0) ? TAG_IDAT : 32'($urandom));
            for (k = 0; k < 12; k++)
                push_byte(8'($urandom), 1'b0);
            cut = $urandom_range(start, file_bytes.size() - 1);
            file_bytes[cut].last = 1'b1;
            while (file_bytes.size() > cut + 1)
                void'(file_bytes.pop_back());
        end
        else
        begin
            // An IHDR that fails one check, its failing byte sometimes marked last.
            ending_name = "a rejected IHDR";
            case ($urandom_range(0, 2))
                0:       fault = ERR_DEPTH;
                1:       fault = ERR_COLOUR;
                default: fault = ERR_INTERLACE;
            endcase
            fail_at = (fault == ERR_DEPTH)  ? IHDR_DEPTH_IDX :
                      (fault == ERR_COLOUR) ? IHDR_COLOUR_IDX : IHDR_INTERLACE_IDX;
            push_word(32'd13);
            push_word(TAG_IHDR);
            for (k = 0; k < 13; k++)
                push_byte(ihdr_field(k, fault), (k == fail_at) && ($urandom_range(0, 1) != 0));
        end

        repeat ($urandom_range(20, 40))
            push_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Wait before a transaction: none during a calm run, else drawn at random; calm runs give back-to-back ones.
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.payload_valid != want.payload_valid)
            report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
        if (got.image_width != want.image_width)
            report_mismatch("image_width", got.image_width, want.image_width);
        if (got.image_height != want.image_height)
            report_mismatch("image_height", got.image_height, want.image_height);
        if (got.sample_depth != want.sample_depth)
            report_mismatch("sample_depth", got.sample_depth, want.sample_depth);
        if (got.header_seen != want.header_seen)
            report_mismatch("header_seen", got.header_seen, want.header_seen);
        if (got.stream_done != want.stream_done)
            report_mismatch("stream_done", got.stream_done, want.stream_done);
        if (got.error_code != want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
    endtask

    // Input transactions advance the model; output transactions are checked.
    always @(posedge clk)
    begin
        result_t got;
        result_t predicted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = deframe_byte(data_byte, last_byte);
                if (file_bytes[accepted_count].typed)
                    due_outputs.push_back(file_bytes[accepted_count].want);
                else
                    due_outputs.push_back(predicted);
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                got = '{payload_byte, payload_valid, image_width, image_height,
                        sample_depth, header_seen, stream_done, error_code};
                if (due_outputs.size() == 0)
                    report_mismatch("result with nothing expected", 32'(got.payload_byte), 0);
                else
                    compare_result(got, due_outputs.pop_front());
                if (got.payload_valid)
                    payload_count++;
                result_count++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, due_outputs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver side: out_ready held off at random between transactions.
    initial
    begin
        int unsigned gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_wait(recv_calm);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned gap;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;

        foreach (OPENING[i])
            file_bytes.push_back(OPENING[i]);
        build_random_file();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sender side: valid stays up with the same byte until taken.
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            gap = draw_wait(send_calm);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= file_bytes[i].data;
            last_byte <= file_bytes[i].last;
            do
                @(posedge clk);
            while (!in_ready);
        end
        in_valid <= 1'b0;

        while (accepted_count < file_bytes.size() || due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_outputs.size() != 0)
            report_mismatch("results never delivered", due_outputs.size(), 0);

        $display("Sent %0d file bytes (%0d from the opening table), checked %0d results.",
                 file_bytes.size(), $size(OPENING), result_count);
        $display("%0d IDAT bytes passed out; the file ended with %s, final code %s.",
                 payload_count, ending_name, m_error.name());
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
